// ===== rtl/gieq_pkg.sv =====
// Shared types, codes and constants of the GPIO interrupt event queue.
package gieq_pkg;

   // Default ring depth for the top-level parameter.
   localparam int RING_DEPTH_DEF = 64;
   // Most lines that are ever honored, and number of pins that can be selected.
   localparam int MAX_LINES = 4;
   localparam int PIN_COUNT = 16;

   // Width of a status word, and of the reported result fields.
   localparam int WORD_W  = 16;
   localparam int COUNT_W = 7;

   // Operation codes.
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_STATS = 2'd2;

   // Result codes.
   localparam logic [2:0] RC_OK         = 3'd0;
   localparam logic [2:0] RC_EMPTY      = 3'd1;
   localparam logic [2:0] RC_NOT_CONFIG = 3'd2;
   localparam logic [2:0] RC_DROPPED    = 3'd3;
   localparam logic [2:0] RC_NOTHING    = 3'd4;

   // Trigger codes; any other code follows the pin level.
   localparam logic [1:0] TRIG_RISING  = 2'd0;
   localparam logic [1:0] TRIG_FALLING = 2'd1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_NUM_LINES   = 2'd0;
   localparam logic [1:0] CSR_PIN_MAP     = 2'd1;
   localparam logic [1:0] CSR_TRIGGER_MAP = 2'd2;
   localparam logic [1:0] CSR_ID_MAP      = 2'd3;

   typedef struct packed {
      logic [2:0]  num_lines;
      logic [15:0] pin_map;
      logic [7:0]  trigger_map;
      logic [31:0] id_map;
   } cfg_type;

   // Outcome of the line decode for one item.
   typedef struct packed {
      logic              configured;
      logic [WORD_W-1:0] active_mask;
      logic              load;
      logic              found;
      logic [WORD_W-1:0] rest_word;
      logic [7:0]        line_id;
      logic              edge_rise;
      logic              level;
   } sel_type;

endpackage

// ===== rtl/gieq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module gieq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gieq_line_sel.sv =====
// Line decode: active pin mask and first-line priority select with edge and level.
module gieq_line_sel (
   input  gieq_pkg::cfg_type                  cfg,
   input  logic [gieq_pkg::WORD_W-1:0]        decode_word,
   input  logic [gieq_pkg::WORD_W-1:0]        head_word,
   input  logic [gieq_pkg::WORD_W-1:0]        pin_levels,
   output gieq_pkg::sel_type                  sel
);

   localparam int LINE_SLOTS = (gieq_pkg::MAX_LINES < 7) ? gieq_pkg::MAX_LINES : 7;

   logic [2:0]                  used;
   logic [31:0]                 pin_ext;
   logic [15:0]                 trig_ext;
   logic [63:0]                 id_ext;
   logic [gieq_pkg::WORD_W-1:0] mask [LINE_SLOTS];
   logic [gieq_pkg::WORD_W-1:0] active;
   logic [gieq_pkg::WORD_W-1:0] word_src;
   logic [gieq_pkg::WORD_W-1:0] sel_mask;
   logic [1:0]                  trig;
   logic [3:0]                  pin;
   logic                        found;
   logic [7:0]                  line_id;

   // Lines past the register width read as pin zero, rising edge, id zero.
   assign pin_ext  = 32'(cfg.pin_map);
   assign trig_ext = 16'(cfg.trigger_map);
   assign id_ext   = 64'(cfg.id_map);
   assign used     = (32'(cfg.num_lines) > gieq_pkg::MAX_LINES) ?
                     3'(gieq_pkg::MAX_LINES) : cfg.num_lines;

   always_comb begin
      active = '0;
      for (int i = 0; i < LINE_SLOTS; i++) begin
         pin     = pin_ext[4*i +: 4];
         mask[i] = '0;
         if ((3'(i) < used) && (32'(pin) < gieq_pkg::PIN_COUNT)) begin
            mask[i] = gieq_pkg::WORD_W'(1) << pin;
         end
         active = active | mask[i];
      end
   end

   assign word_src = (decode_word == '0) ? (head_word & active) : decode_word;

   always_comb begin
      found    = 1'b0;
      sel_mask = '0;
      trig     = gieq_pkg::TRIG_RISING;
      line_id  = '0;
      for (int i = 0; i < LINE_SLOTS; i++) begin
         if (!found && ((word_src & mask[i]) != '0)) begin
            found    = 1'b1;
            sel_mask = mask[i];
            trig     = trig_ext[2*i +: 2];
            line_id  = id_ext[8*i +: 8];
         end
      end
   end

   always_comb begin
      sel.configured  = (used != 3'd0);
      sel.active_mask = active;
      sel.load        = (decode_word == '0);
      sel.found       = found;
      sel.rest_word   = found ? (word_src & ~sel_mask) : '0;
      sel.line_id     = line_id;
      sel.level       = ((pin_levels & sel_mask) != '0);
      if (trig == gieq_pkg::TRIG_RISING) begin
         sel.edge_rise = 1'b1;
      end else if (trig == gieq_pkg::TRIG_FALLING) begin
         sel.edge_rise = 1'b0;
      end else begin
         sel.edge_rise = sel.level;
      end
   end

endmodule

// ===== rtl/gpio_irq_event_queue_top.sv =====
// Top level of the GPIO interrupt event queue: channels, ring control and statistics.
//
//   Channel   Direction  Handshake               Carries
//   req_      in         req_valid / req_stall   operation, status word, pin levels, time
//   rsp_      out        rsp_valid / rsp_stall   result code, event fields, statistics
//   csr_      in         csr_write_enable        line count, pin, trigger and id maps
//
// One item is taken per clock cycle while req_stall is low. From input to result register
// the path is the line decode plus one index add and compare.
// Reset is synchronous and clears the indexes, counters, decode word and configuration;
// the status ring is not cleared, so there is no clearing pass after reset.
// While a result is stalled the input register holds its item, and the input channel
// stalls only when that register is full and the result is stalled.
module gpio_irq_event_queue_top #(
   parameter int RING_DEPTH = gieq_pkg::RING_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_status_word,
   input  logic [15:0] req_pin_levels,
   input  logic [31:0] req_timestamp_us,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_code,
   output logic [7:0]  rsp_event_line,
   output logic        rsp_event_edge,
   output logic        rsp_event_level,
   output logic [31:0] rsp_event_time,
   output logic [6:0]  rsp_pending_count,
   output logic [31:0] rsp_drop_total,
   output logic [6:0]  rsp_peak_fill,

   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   localparam int ADDR_W   = $clog2(RING_DEPTH);
   localparam int IDX_W    = $clog2(2 * RING_DEPTH);
   localparam int IDX_LAST = 2 * RING_DEPTH - 1;
   localparam int WORD_W   = gieq_pkg::WORD_W;
   localparam int COUNT_W  = gieq_pkg::COUNT_W;

   // The indexes run modulo twice the depth, so full and empty differ.
   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(IDX_LAST)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] idx_addr(input logic [IDX_W-1:0] idx);
      return (idx >= IDX_W'(RING_DEPTH)) ? ADDR_W'(idx - IDX_W'(RING_DEPTH)) : ADDR_W'(idx);
   endfunction

   function automatic logic [IDX_W-1:0] fill_of(input logic [IDX_W-1:0] w,
                                                input logic [IDX_W-1:0] r);
      return (w >= r) ? (w - r) : (w + IDX_W'(2 * RING_DEPTH) - r);
   endfunction

   // Configuration registers.
   gieq_pkg::cfg_type cfg_ff;
   gieq_pkg::cfg_type cfg_in;

   // Input register.
   logic              req_valid_ff, req_valid_in;
   logic [1:0]        req_op_ff;
   logic [WORD_W-1:0] req_status_ff;
   logic [WORD_W-1:0] req_levels_ff;
   logic [31:0]       req_time_ff;

   // Queue state.
   logic [IDX_W-1:0]  write_index_ff, write_index_in;
   logic [IDX_W-1:0]  read_index_ff, read_index_in;
   logic [31:0]       drop_ff, drop_in;
   logic [IDX_W-1:0]  peak_ff, peak_in;
   logic [WORD_W-1:0] decode_word_ff, decode_word_in;

   // Head-of-ring read path with bypass for a word written in the read cycle.
   logic              bypass_hit_ff, bypass_hit_in;
   logic [WORD_W-1:0] bypass_data_ff;
   logic [WORD_W-1:0] ram_rdata;
   logic [WORD_W-1:0] head_word;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [WORD_W-1:0] push_word;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        code_ff, code_in;
   logic [7:0]        line_ff, line_in;
   logic              edge_ff, edge_in;
   logic              level_ff, level_in;
   logic [31:0]       time_ff, time_in;
   logic [COUNT_W-1:0] pending_ff, pending_in;

   logic              fire;
   logic              req_take;
   logic [IDX_W-1:0]  fill_now;
   logic [IDX_W-1:0]  fill_after;

   gieq_pkg::sel_type sel;

   // The item in the input register completes when the result register can take it.
   assign fire      = req_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = req_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   assign fill_now  = fill_of(write_index_ff, read_index_ff);
   assign head_word = bypass_hit_ff ? bypass_data_ff : ram_rdata;
   assign push_word = req_status_ff & sel.active_mask;
   assign wr_addr   = idx_addr(write_index_ff);
   assign rd_addr   = idx_addr(read_index_in);

   gieq_line_sel u_line_sel (
      .cfg         (cfg_ff),
      .decode_word (decode_word_ff),
      .head_word   (head_word),
      .pin_levels  (req_levels_ff),
      .sel         (sel)
   );

   gieq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (push_word),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // Configuration writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            gieq_pkg::CSR_NUM_LINES:   cfg_in.num_lines   = csr_write_data[2:0];
            gieq_pkg::CSR_PIN_MAP:     cfg_in.pin_map     = csr_write_data[15:0];
            gieq_pkg::CSR_TRIGGER_MAP: cfg_in.trigger_map = csr_write_data[7:0];
            gieq_pkg::CSR_ID_MAP:      cfg_in.id_map      = csr_write_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   // Item processing: one operation against the queue state.
   always_comb begin
      write_index_in = write_index_ff;
      read_index_in  = read_index_ff;
      drop_in        = drop_ff;
      decode_word_in = decode_word_ff;
      wr_en          = 1'b0;
      code_in        = gieq_pkg::RC_OK;
      line_in        = '0;
      edge_in        = 1'b0;
      level_in       = 1'b0;
      time_in        = '0;
      if (fire) begin
         unique case (req_op_ff)
            gieq_pkg::OP_PUSH: begin
               if (push_word == '0) begin
                  code_in = gieq_pkg::RC_NOTHING;
               end else if (fill_now >= IDX_W'(RING_DEPTH)) begin
                  code_in = gieq_pkg::RC_DROPPED;
                  drop_in = drop_ff + 32'd1;
               end else begin
                  wr_en          = 1'b1;
                  write_index_in = idx_inc(write_index_ff);
               end
            end
            gieq_pkg::OP_POP: begin
               if (!sel.configured) begin
                  code_in = gieq_pkg::RC_NOT_CONFIG;
               end else if (sel.load && (fill_now == '0)) begin
                  code_in = gieq_pkg::RC_EMPTY;
               end else begin
                  if (sel.load) begin
                     read_index_in = idx_inc(read_index_ff);
                  end
                  // A word that matches no line any more is dropped as empty.
                  decode_word_in = sel.rest_word;
                  if (sel.found) begin
                     line_in  = sel.line_id;
                     edge_in  = sel.edge_rise;
                     level_in = sel.level;
                     time_in  = req_time_ff;
                  end else begin
                     code_in = gieq_pkg::RC_EMPTY;
                  end
               end
            end
            default: begin
               code_in = sel.configured ? gieq_pkg::RC_OK : gieq_pkg::RC_NOT_CONFIG;
            end
         endcase
      end
   end

   assign fill_after = fill_of(write_index_in, read_index_in);
   assign peak_in    = (fill_after > peak_ff) ? fill_after : peak_ff;
   assign pending_in = COUNT_W'(fill_after) + COUNT_W'(decode_word_in != '0);

   // A word written to the slot being read shows up through the bypass.
   assign bypass_hit_in = wr_en && (wr_addr == rd_addr);

   assign req_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : req_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff         <= '0;
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         write_index_ff <= '0;
         read_index_ff  <= '0;
         drop_ff        <= '0;
         peak_ff        <= '0;
         decode_word_ff <= '0;
         bypass_hit_ff  <= 1'b0;
      end else begin
         cfg_ff         <= cfg_in;
         req_valid_ff   <= req_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         write_index_ff <= write_index_in;
         read_index_ff  <= read_index_in;
         drop_ff        <= drop_in;
         peak_ff        <= peak_in;
         decode_word_ff <= decode_word_in;
         bypass_hit_ff  <= bypass_hit_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_op_ff     <= req_operation;
         req_status_ff <= req_status_word;
         req_levels_ff <= req_pin_levels;
         req_time_ff   <= req_timestamp_us;
      end
      if (wr_en) begin
         bypass_data_ff <= push_word;
      end
      if (fire) begin
         code_ff    <= code_in;
         line_ff    <= line_in;
         edge_ff    <= edge_in;
         level_ff   <= level_in;
         time_ff    <= time_in;
         pending_ff <= pending_in;
      end
   end

   // Statistics on each result are the values after its item.
   logic [31:0]        drop_stat_ff;
   logic [COUNT_W-1:0] peak_stat_ff;

   always_ff @(posedge clock) begin
      if (fire) begin
         drop_stat_ff <= drop_in;
         peak_stat_ff <= COUNT_W'(peak_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_code   = code_ff;
   assign rsp_event_line    = line_ff;
   assign rsp_event_edge    = edge_ff;
   assign rsp_event_level   = level_ff;
   assign rsp_event_time    = time_ff;
   assign rsp_pending_count = pending_ff;
   assign rsp_drop_total    = drop_stat_ff;
   assign rsp_peak_fill     = peak_stat_ff;

   // The ring never holds more than its depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_now <= IDX_W'(RING_DEPTH))
      else $error("ring fill exceeds depth");

   // The recorded peak is never below the present fill.
   a_peak_covers_fill: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= fill_now)
      else $error("peak fill below current fill");

   // A stored push grows the fill by exactly one.
   a_push_grows_fill: assert property (@(posedge clock) disable iff (reset)
      (fire && wr_en) |=> (fill_now == $past(fill_now) + 1'b1))
      else $error("stored push did not grow fill by one");

   // Event fields are zero on every result other than a completed event.
   a_event_quiet: assert property (@(posedge clock) disable iff (reset)
      (fire && (code_in != gieq_pkg::RC_OK)) |=>
         ((rsp_event_line == '0) && (rsp_event_time == '0) && !rsp_event_edge
          && !rsp_event_level))
      else $error("event fields set on a non-event result");

endmodule
